// ===== hw/rtl/bfgql_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfgql_pkg: shared types and constants for the glyph quad layout block
// Opcodes, control characters, result kinds and fixed-point helpers.
// ----------------------------------------------------------------------------
package bfgql_pkg;

	// input opcodes
	localparam logic [1:0] OP_MAP_LOAD = 2'd0;
	localparam logic [1:0] OP_START    = 2'd1;
	localparam logic [1:0] OP_CHAR     = 2'd2;
	localparam logic [1:0] OP_END      = 2'd3;

	// control characters
	localparam logic [7:0] CHAR_TAB = 8'h09;
	localparam logic [7:0] CHAR_LF  = 8'h0A;
	localparam logic [7:0] CHAR_CR  = 8'h0D;

	// result kinds
	localparam logic KIND_VERTEX = 1'b0;
	localparam logic KIND_BOX    = 1'b1;

	// configuration register indexes
	localparam logic [2:0] REG_CELL_W    = 3'd0;
	localparam logic [2:0] REG_CELL_H    = 3'd1;
	localparam logic [2:0] REG_SPACING_X = 3'd2;
	localparam logic [2:0] REG_SPACING_Y = 3'd3;
	localparam logic [2:0] REG_TAB_CELLS = 3'd4;
	localparam logic [2:0] REG_LINE_LIM  = 3'd5;
	localparam logic [2:0] REG_CROP_U    = 3'd6;
	localparam logic [2:0] REG_CROP_V    = 3'd7;

	// texture coordinate one, Q1.16
	localparam logic [16:0] TEX_ONE = 17'd65536;

	// saturate a 26-bit signed sum to the Q15.8 range
	function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
		logic signed [23:0] r;
		if (v < -26'sd8388608) r = -24'sd8388608;
		else if (v > 26'sd8388607) r = 24'sd8388607;
		else r = v[23:0];
		return r;
	endfunction

	// clamp a texture coordinate to 0..1.0
	function automatic logic [16:0] clamp_tex(input logic signed [26:0] v);
		logic [16:0] r;
		if (v < 27'sd0) r = 17'd0;
		else if (v > 27'sd65536) r = TEX_ONE;
		else r = v[16:0];
		return r;
	endfunction

endpackage

// ===== hw/rtl/bitmap_font_glyph_quad_layout.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_font_glyph_quad_layout: text string to textured glyph quads
// Looks up each character in a synchronous glyph map, emits six vertices per
// mapped glyph, moves the cursor with wrap and tabs, and reports the box.
// ----------------------------------------------------------------------------
// Map load, start string, CR and LF complete on acceptance; end string goes through S_BOX.
// A character is accepted, looked up, then emits six vertices if mapped (held while
// results are stalled) and advances the cursor; only then is a new item taken.
// A tab adds its whole step in S_TAB_ADD without a line limit, else steps cell by cell in S_TAB_STEP.
// The box result is registered from S_BOX, a vertex from S_EMIT after S_LOOKUP.
// Reset (arst_n low) invalidates all map entries and zeroes cursor and box.
module bitmap_font_glyph_quad_layout #(
	parameter int FONT_COLUMNS = 16,
	parameter int FONT_ROWS    = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	// input channel
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          opcode,
	input  logic [7:0]          char_code,
	input  logic [7:0]          glyph_index,
	input  logic                entry_valid,
	input  logic signed [23:0]  origin_x,
	input  logic signed [23:0]  origin_y,
	// output channel
	output logic                out_valid,
	input  logic                out_ready,
	output logic                kind,
	output logic signed [23:0]  pos_x,
	output logic signed [23:0]  pos_y,
	output logic [16:0]         tex_u,
	output logic [16:0]         tex_v,
	output logic signed [23:0]  box_max_x,
	output logic signed [23:0]  box_max_y,
	output logic                box_empty,
	output logic                last
);

	localparam int TW = 65536 / FONT_COLUMNS;
	localparam int TH = 65536 / FONT_ROWS;
	localparam logic signed [26:0] TW27 = 27'(TW);
	localparam logic signed [26:0] TH27 = 27'(TH);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOKUP,
		S_EMIT,
		S_ADV,
		S_TAB_ADD,
		S_TAB_STEP,
		S_BOX
	} state_t;

	state_t state_q;

	// configuration registers
	logic [15:0] cell_w_q, cell_h_q, spc_x_q, spc_y_q, crop_u_q, crop_v_q;
	logic [3:0]  tab_cells_q;
	logic [7:0]  line_lim_q;

	// layout state
	logic signed [23:0] cur_x_q, cur_y_q, start_x_q;
	logic [7:0]         cells_q;
	logic signed [23:0] box_lx_q, box_ly_q, box_hx_q, box_hy_q;
	logic               box_has_q;

	// glyph map: index memory plus valid flops
	logic [7:0] map_mem [256];
	logic       map_vld_q [256];
	logic [7:0] map_rd_q;
	logic       map_rd_vld_q;

	// per glyph working registers
	logic signed [23:0] xl_q, xr_q, yt_q, yb_q;
	logic [16:0]        ul_q, ur_q, vt_q, vb_q;
	logic [2:0]         vtx_q;
	logic [3:0]         tab_cnt_q;
	logic [20:0]        tab_step_q;

	// output register
	logic               out_valid_q, kind_q, box_empty_q, last_q;
	logic signed [23:0] pos_x_q, pos_y_q, box_max_x_q, box_max_y_q;
	logic [16:0]        tex_u_q, tex_v_q;

	// atlas corner tables
	logic [16:0] a_lut [256];
	logic [24:0] b_lut [256];

	for (genvar gi = 0; gi < 256; gi++) begin : g_lut
		assign a_lut[gi] = 17'((gi % FONT_COLUMNS) * TW);
		assign b_lut[gi] = 25'((gi / FONT_COLUMNS) * TH);
	end

	logic in_acc, out_free, out_load;
	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign out_load = out_free && (state_q == S_EMIT || state_q == S_BOX);

	// cursor arithmetic
	logic [16:0]        cell_step, line_step;
	logic signed [23:0] adv_x, nl_y, tab_x, xr_n, yb_n;
	logic [7:0]         cells_inc;
	logic               wrap;

	assign cell_step = {1'b0, cell_w_q} + {1'b0, spc_x_q};
	assign line_step = {1'b0, cell_h_q} + {1'b0, spc_y_q};
	assign adv_x     = bfgql_pkg::sat24({{2{cur_x_q[23]}}, cur_x_q} + {9'd0, cell_step});
	assign nl_y      = bfgql_pkg::sat24({{2{cur_y_q[23]}}, cur_y_q} - {9'd0, line_step});
	assign tab_x     = bfgql_pkg::sat24({{2{cur_x_q[23]}}, cur_x_q} + {5'd0, tab_step_q});
	assign xr_n      = bfgql_pkg::sat24({{2{cur_x_q[23]}}, cur_x_q} + {10'd0, cell_w_q});
	assign yb_n      = bfgql_pkg::sat24({{2{cur_y_q[23]}}, cur_y_q} - {10'd0, cell_h_q});
	assign cells_inc = cells_q + 8'd1;
	assign wrap      = (cells_inc >= line_lim_q);

	// texture corners of the looked up cell
	logic signed [26:0] a27, b27, cu27, cv27;
	assign a27  = {10'd0, a_lut[map_rd_q]};
	assign b27  = {2'd0, b_lut[map_rd_q]};
	assign cu27 = {11'd0, crop_u_q};
	assign cv27 = {11'd0, crop_v_q};

	// vertex corner selection, order v1 v3 v2 v1 v4 v3
	logic vtx_right, vtx_bottom;
	assign vtx_right  = (vtx_q == 3'd1) || (vtx_q == 3'd2) || (vtx_q == 3'd5);
	assign vtx_bottom = (vtx_q == 3'd1) || (vtx_q == 3'd4) || (vtx_q == 3'd5);

	// glyph map memory write and read
	always_ff @(posedge clk) begin
		if (in_acc && opcode == bfgql_pkg::OP_MAP_LOAD) begin
			map_mem[char_code] <= glyph_index;
		end
		if (in_acc) begin
			map_rd_q <= map_mem[char_code];
		end
	end

	// valid bits of the glyph map
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 256; i++) map_vld_q[i] <= 1'b0;
			map_rd_vld_q <= 1'b0;
		end else if (in_acc) begin
			if (opcode == bfgql_pkg::OP_MAP_LOAD) map_vld_q[char_code] <= entry_valid;
			map_rd_vld_q <= map_vld_q[char_code];
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_w_q    <= 16'd2048;
			cell_h_q    <= 16'd2048;
			spc_x_q     <= 16'd0;
			spc_y_q     <= 16'd0;
			tab_cells_q <= 4'd4;
			line_lim_q  <= 8'd0;
			crop_u_q    <= 16'd0;
			crop_v_q    <= 16'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				bfgql_pkg::REG_CELL_W:    cell_w_q    <= cfg_data;
				bfgql_pkg::REG_CELL_H:    cell_h_q    <= cfg_data;
				bfgql_pkg::REG_SPACING_X: spc_x_q     <= cfg_data;
				bfgql_pkg::REG_SPACING_Y: spc_y_q     <= cfg_data;
				bfgql_pkg::REG_TAB_CELLS: tab_cells_q <= cfg_data[3:0];
				bfgql_pkg::REG_LINE_LIM:  line_lim_q  <= cfg_data[7:0];
				bfgql_pkg::REG_CROP_U:    crop_u_q    <= cfg_data;
				bfgql_pkg::REG_CROP_V:    crop_v_q    <= cfg_data;
				default:                  ;
			endcase
		end
	end

	// sequencer, layout state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			start_x_q   <= '0;
			cells_q     <= '0;
			box_lx_q    <= '0;
			box_ly_q    <= '0;
			box_hx_q    <= '0;
			box_hy_q    <= '0;
			box_has_q   <= 1'b0;
			xl_q        <= '0;
			xr_q        <= '0;
			yt_q        <= '0;
			yb_q        <= '0;
			ul_q        <= '0;
			ur_q        <= '0;
			vt_q        <= '0;
			vb_q        <= '0;
			vtx_q       <= '0;
			tab_cnt_q   <= '0;
			tab_step_q  <= '0;
			out_valid_q <= 1'b0;
			kind_q      <= 1'b0;
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			tex_u_q     <= '0;
			tex_v_q     <= '0;
			box_max_x_q <= '0;
			box_max_y_q <= '0;
			box_empty_q <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			// result loaded, or taken downstream
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						case (opcode)
							bfgql_pkg::OP_MAP_LOAD: ;
							bfgql_pkg::OP_START: begin
								cur_x_q   <= origin_x;
								start_x_q <= origin_x;
								cur_y_q   <= origin_y;
								cells_q   <= '0;
								box_lx_q  <= '0;
								box_ly_q  <= '0;
								box_hx_q  <= '0;
								box_hy_q  <= '0;
								box_has_q <= 1'b0;
							end
							bfgql_pkg::OP_END: state_q <= S_BOX;
							bfgql_pkg::OP_CHAR: begin
								if (char_code == bfgql_pkg::CHAR_CR) begin
									// carriage return is ignored
								end else if (char_code == bfgql_pkg::CHAR_LF) begin
									cur_x_q <= start_x_q;
									cur_y_q <= nl_y;
									cells_q <= '0;
								end else if (char_code == bfgql_pkg::CHAR_TAB) begin
									tab_step_q <= {4'd0, cell_step} * {17'd0, tab_cells_q};
									tab_cnt_q  <= tab_cells_q;
									state_q    <= (line_lim_q == 8'd0) ? S_TAB_ADD
									                                   : S_TAB_STEP;
								end else begin
									state_q <= S_LOOKUP;
								end
							end
							default: ;
						endcase
					end
				end

				// map entry is read; if valid, set up the quad and grow the box
				S_LOOKUP: begin
					if (map_rd_vld_q) begin
						xl_q  <= cur_x_q;
						yt_q  <= cur_y_q;
						xr_q  <= xr_n;
						yb_q  <= yb_n;
						ul_q  <= bfgql_pkg::clamp_tex(a27 + cu27);
						ur_q  <= bfgql_pkg::clamp_tex(a27 + TW27 - cu27);
						vt_q  <= bfgql_pkg::TEX_ONE - bfgql_pkg::clamp_tex(b27 + cv27);
						vb_q  <= bfgql_pkg::TEX_ONE - bfgql_pkg::clamp_tex(b27 + TH27 - cv27);
						vtx_q <= '0;
						if (!box_has_q) begin
							box_lx_q <= cur_x_q;
							box_hx_q <= xr_n;
							box_ly_q <= yb_n;
							box_hy_q <= cur_y_q;
						end else begin
							if (cur_x_q < box_lx_q) box_lx_q <= cur_x_q;
							if (xr_n > box_hx_q)    box_hx_q <= xr_n;
							if (yb_n < box_ly_q)    box_ly_q <= yb_n;
							if (cur_y_q > box_hy_q) box_hy_q <= cur_y_q;
						end
						box_has_q <= 1'b1;
						state_q   <= S_EMIT;
					end else begin
						state_q <= S_ADV;
					end
				end

				// six vertices through the output register
				S_EMIT: begin
					if (out_free) begin
						kind_q      <= bfgql_pkg::KIND_VERTEX;
						pos_x_q     <= vtx_right ? xr_q : xl_q;
						pos_y_q     <= vtx_bottom ? yb_q : yt_q;
						tex_u_q     <= vtx_right ? ur_q : ul_q;
						tex_v_q     <= vtx_bottom ? vb_q : vt_q;
						box_max_x_q <= '0;
						box_max_y_q <= '0;
						box_empty_q <= 1'b0;
						last_q      <= (vtx_q == 3'd5);
						if (vtx_q == 3'd5) state_q <= S_ADV;
						else vtx_q <= vtx_q + 3'd1;
					end
				end

				// advance one cell, wrapping at the line limit; tab steps repeat until the count is spent
				S_ADV, S_TAB_STEP: begin
					if (state_q == S_TAB_STEP && tab_cnt_q == 4'd0) begin
						state_q <= S_IDLE;
					end else begin
						if (line_lim_q == 8'd0) begin
							cur_x_q <= adv_x;
						end else if (wrap) begin
							cur_x_q <= start_x_q;
							cur_y_q <= nl_y;
							cells_q <= '0;
						end else begin
							cur_x_q <= adv_x;
							cells_q <= cells_inc;
						end
						tab_cnt_q <= tab_cnt_q - 4'd1;
						if (state_q == S_ADV) state_q <= S_IDLE;
					end
				end

				S_TAB_ADD: begin
					cur_x_q <= tab_x;
					state_q <= S_IDLE;
				end

				// bounding box result
				S_BOX: begin
					if (out_free) begin
						kind_q      <= bfgql_pkg::KIND_BOX;
						pos_x_q     <= box_has_q ? box_lx_q : '0;
						pos_y_q     <= box_has_q ? box_ly_q : '0;
						box_max_x_q <= box_has_q ? box_hx_q : '0;
						box_max_y_q <= box_has_q ? box_hy_q : '0;
						tex_u_q     <= '0;
						tex_v_q     <= '0;
						box_empty_q <= !box_has_q;
						last_q      <= 1'b1;
						state_q     <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign pos_x     = pos_x_q;
	assign pos_y     = pos_y_q;
	assign tex_u     = tex_u_q;
	assign tex_v     = tex_v_q;
	assign box_max_x = box_max_x_q;
	assign box_max_y = box_max_y_q;
	assign box_empty = box_empty_q;
	assign last      = last_q;

	// a box result always closes its transaction
	a_box_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == bfgql_pkg::KIND_BOX |-> last)
		else $error("box result without last");

	// empty flag only on box results
	a_empty_box: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && box_empty |-> kind == bfgql_pkg::KIND_BOX)
		else $error("empty flag on a vertex");

	// vertex counter stays within one quad
	a_vtx_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT |-> vtx_q <= 3'd5)
		else $error("vertex counter out of range");

	// a vertex with last leaves the emit state
	a_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT && out_free && vtx_q == 3'd5 |=> state_q == S_ADV)
		else $error("quad did not finish");

endmodule

// ===== sim/glyph_layout_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_layout_checker: layout predictor and result scoreboard
// Watches the configuration port and both channels, computes the vertices and
// boxes each accepted item should produce, and compares them in order.
// ----------------------------------------------------------------------------
module glyph_layout_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [1:0]         opcode,
	input  logic [7:0]         char_code,
	input  logic [7:0]         glyph_index,
	input  logic               entry_valid,
	input  logic signed [23:0] origin_x,
	input  logic signed [23:0] origin_y,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic               kind,
	input  logic signed [23:0] pos_x,
	input  logic signed [23:0] pos_y,
	input  logic [16:0]        tex_u,
	input  logic [16:0]        tex_v,
	input  logic signed [23:0] box_max_x,
	input  logic signed [23:0] box_max_y,
	input  logic               box_empty,
	input  logic               last,
	output int                 fail_count,
	output int                 pending
);

	typedef struct packed {
		logic              kind;
		logic signed [23:0] px;
		logic signed [23:0] py;
		logic [16:0]       u;
		logic [16:0]       v;
		logic signed [23:0] mx;
		logic signed [23:0] my;
		logic              empty;
		logic              last;
	} layout_result_t;

	localparam longint LO24 = -64'sd8388608;
	localparam longint HI24 = 64'sd8388607;

	layout_result_t expected_results[$];
	logic [15:0] regs [8];
	logic [8:0]  glyph_tbl [256];
	longint cur_x, cur_y, line_x, lo_x, lo_y, hi_x, hi_y;
	int cell_count;
	bit have_box;

	function automatic longint clip24(input longint v);
		if (v < LO24) return LO24;
		if (v > HI24) return HI24;
		return v;
	endfunction

	function automatic longint clip_tex(input longint v);
		if (v < 0) return 0;
		if (v > 65536) return 65536;
		return v;
	endfunction

	function automatic void line_feed();
		cur_x = line_x;
		cur_y = clip24(cur_y - longint'(regs[bfgql_pkg::REG_CELL_H])
			- longint'(regs[bfgql_pkg::REG_SPACING_Y]));
		cell_count = 0;
	endfunction

	function automatic void grow_box(input longint x, input longint y);
		if (!have_box) begin
			lo_x = x; hi_x = x; lo_y = y; hi_y = y; have_box = 1;
		end else begin
			if (x < lo_x) lo_x = x;
			if (x > hi_x) hi_x = x;
			if (y < lo_y) lo_y = y;
			if (y > hi_y) hi_y = y;
		end
	endfunction

	function automatic void advance_cell();
		cur_x = clip24(cur_x + longint'(regs[bfgql_pkg::REG_CELL_W])
			+ longint'(regs[bfgql_pkg::REG_SPACING_X]));
	endfunction

	// six vertices of one quad in the order v1 v3 v2 v1 v4 v3
	function automatic void push_quad(input logic [7:0] idx);
		longint tw, th, a, b, ul, ur, vt, vb, xr, yb, cu, cv;
		longint qx[6], qy[6], qu[6], qv[6];
		layout_result_t r;
		tw = 65536 / 16; th = 65536 / 16;
		a = longint'(idx % 16) * tw;
		b = longint'(idx / 16) * th;
		cu = longint'(regs[bfgql_pkg::REG_CROP_U]);
		cv = longint'(regs[bfgql_pkg::REG_CROP_V]);
		ul = clip_tex(a + cu);
		ur = clip_tex(a + tw - cu);
		vt = 65536 - clip_tex(b + cv);
		vb = 65536 - clip_tex(b + th - cv);
		xr = clip24(cur_x + longint'(regs[bfgql_pkg::REG_CELL_W]));
		yb = clip24(cur_y - longint'(regs[bfgql_pkg::REG_CELL_H]));
		qx = '{cur_x, xr, xr, cur_x, cur_x, xr};
		qy = '{cur_y, yb, cur_y, cur_y, yb, yb};
		qu = '{ul, ur, ur, ul, ul, ur};
		qv = '{vt, vb, vt, vt, vb, vb};
		for (int k = 0; k < 6; k++) begin
			r = '0;
			r.kind = bfgql_pkg::KIND_VERTEX;
			r.px = qx[k][23:0]; r.py = qy[k][23:0];
			r.u = qu[k][16:0];  r.v = qv[k][16:0];
			r.last = (k == 5);
			expected_results = {expected_results, r};
		end
		grow_box(cur_x, cur_y);
		grow_box(xr, yb);
	endfunction

	// layout state update for one accepted transaction
	function automatic void predict_layout(input logic [1:0] op, input logic [7:0] c,
			input logic [7:0] gi, input logic ev, input logic signed [23:0] ox,
			input logic signed [23:0] oy);
		layout_result_t r;
		case (op)
			bfgql_pkg::OP_MAP_LOAD: glyph_tbl[c] = {ev, gi};
			bfgql_pkg::OP_START: begin
				cur_x = ox; line_x = ox; cur_y = oy; cell_count = 0;
				lo_x = 0; lo_y = 0; hi_x = 0; hi_y = 0; have_box = 0;
			end
			bfgql_pkg::OP_END: begin
				r = '0;
				r.kind = bfgql_pkg::KIND_BOX;
				r.last = 1;
				if (have_box) begin
					r.px = lo_x[23:0]; r.py = lo_y[23:0];
					r.mx = hi_x[23:0]; r.my = hi_y[23:0];
				end else r.empty = 1;
				expected_results = {expected_results, r};
			end
			default: begin
				if (c == bfgql_pkg::CHAR_CR) ;
				else if (c == bfgql_pkg::CHAR_LF) line_feed();
				else if (c == bfgql_pkg::CHAR_TAB) begin
					if (regs[bfgql_pkg::REG_LINE_LIM][7:0] == 0)
						cur_x = clip24(cur_x + (longint'(regs[bfgql_pkg::REG_CELL_W]) +
							longint'(regs[bfgql_pkg::REG_SPACING_X])) *
							longint'(regs[bfgql_pkg::REG_TAB_CELLS][3:0]));
					else
						for (int j = 0; j < regs[bfgql_pkg::REG_TAB_CELLS][3:0]; j++) begin
							cell_count = (cell_count + 1) & 8'hff;
							if (cell_count >= regs[bfgql_pkg::REG_LINE_LIM][7:0]) line_feed();
							else advance_cell();
						end
				end else begin
					if (glyph_tbl[c][8]) push_quad(glyph_tbl[c][7:0]);
					advance_cell();
					if (regs[bfgql_pkg::REG_LINE_LIM][7:0] != 0) begin
						cell_count = (cell_count + 1) & 8'hff;
						if (cell_count >= regs[bfgql_pkg::REG_LINE_LIM][7:0]) line_feed();
					end
				end
			end
		endcase
	endfunction

	// watch configuration, inputs and results
	always @(posedge clk or negedge arst_n) begin
		layout_result_t got, exp_r;
		if (!arst_n) begin
			regs[bfgql_pkg::REG_CELL_W]    = 16'd2048;
			regs[bfgql_pkg::REG_CELL_H]    = 16'd2048;
			regs[bfgql_pkg::REG_SPACING_X] = '0;
			regs[bfgql_pkg::REG_SPACING_Y] = '0;
			regs[bfgql_pkg::REG_TAB_CELLS] = 16'd4;
			regs[bfgql_pkg::REG_LINE_LIM]  = '0;
			regs[bfgql_pkg::REG_CROP_U]    = '0;
			regs[bfgql_pkg::REG_CROP_V]    = '0;
			for (int i = 0; i < 256; i++) glyph_tbl[i] = '0;
			cur_x = 0; cur_y = 0; line_x = 0; cell_count = 0;
			lo_x = 0; lo_y = 0; hi_x = 0; hi_y = 0; have_box = 0;
			expected_results.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (cfg_we)
				regs[cfg_index] = cfg_data;
			if (in_valid && in_ready)
				predict_layout(opcode, char_code, glyph_index, entry_valid, origin_x, origin_y);
			if (out_valid && out_ready) begin
				got = '{kind, pos_x, pos_y, tex_u, tex_v, box_max_x, box_max_y,
					box_empty, last};
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h", $time, got);
					fail_count <= fail_count + 1;
				end else begin
					exp_r = expected_results.pop_front();
					if (got !== exp_r) begin
						$display("%0t: result mismatch, expected %p, actual %p",
							$time, exp_r, got);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= expected_results.size();
		end
	end

endmodule

// ===== sim/bitmap_font_glyph_quad_layout_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_font_glyph_quad_layout_tb: text layout block testbench
// Loads glyph maps, writes register settings between phases and sends
// directed and random strings with random idling on both channels.
// ----------------------------------------------------------------------------
module bitmap_font_glyph_quad_layout_tb;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [15:0]        cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         opcode;
	logic [7:0]         char_code;
	logic [7:0]         glyph_index;
	logic               entry_valid;
	logic signed [23:0] origin_x;
	logic signed [23:0] origin_y;
	logic               out_valid;
	logic               out_ready;
	logic               kind;
	logic signed [23:0] pos_x;
	logic signed [23:0] pos_y;
	logic [16:0]        tex_u;
	logic [16:0]        tex_v;
	logic signed [23:0] box_max_x;
	logic signed [23:0] box_max_y;
	logic               box_empty;
	logic               last;
	int                 fail_count;
	int                 pending;
	bit                 quiet_tail;
	bit                 long_hold;

	bitmap_font_glyph_quad_layout u_top (.*);

	glyph_layout_checker u_checker (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// receiver: random stall bursts, one long hold-off on request
	initial begin
		int n;
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				out_ready <= 0;
				repeat (300) @(posedge clk);
				long_hold = 0;
			end
			if (!quiet_tail && $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 11);
				out_ready <= 0;
				repeat (n) @(posedge clk);
			end
			out_ready <= 1;
			@(posedge clk);
		end
	end

	// send one transaction, with a possible idle burst first
	task automatic send_item(input logic [1:0] op, input logic [7:0] c,
			input logic [7:0] gi, input logic ev,
			input logic signed [23:0] ox, input logic signed [23:0] oy);
		int n;
		if (!quiet_tail && $urandom_range(0, 4) == 0) begin
			n = $urandom_range(1, 11);
			in_valid <= 0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1;
		opcode <= op; char_code <= c; glyph_index <= gi; entry_valid <= ev;
		origin_x <= ox; origin_y <= oy;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic send_char(input logic [7:0] c);
		send_item(bfgql_pkg::OP_CHAR, c, 8'($urandom), 1'($urandom),
			24'($urandom), 24'($urandom));
	endtask

	// wait for the block to drain, then let it settle
	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// one register write, then cfg_we is dropped again
	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	task automatic load_map(input bit all_valid, input int count);
		for (int i = 0; i < count; i++)
			send_item(bfgql_pkg::OP_MAP_LOAD, all_valid ? i[7:0] : 8'($urandom),
				8'($urandom), all_valid ? 1'b1 : ($urandom_range(0, 3) != 0),
				24'($urandom), 24'($urandom));
	endtask

	// random character: mostly any byte value, some LF, TAB and CR codes
	function automatic logic [7:0] pick_char();
		case ($urandom_range(0, 9))
			0: return bfgql_pkg::CHAR_LF;
			1: return bfgql_pkg::CHAR_TAB;
			2: return bfgql_pkg::CHAR_CR;
			default: return 8'($urandom);
		endcase
	endfunction

	// origin anywhere, or near zero
	function automatic logic signed [23:0] pick_origin();
		if ($urandom_range(0, 1) != 0) return 24'($urandom);
		return 24'($urandom_range(0, 8192)) - 24'sd4096;
	endfunction

	task automatic random_string(input int len);
		send_item(bfgql_pkg::OP_START, 8'($urandom), 8'($urandom), 1'($urandom),
			pick_origin(), pick_origin());
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 29) == 0)
				send_item(bfgql_pkg::OP_END, 8'($urandom), 8'd0, 1'b0, 24'sd0, 24'sd0);
			else send_char(pick_char());
		end
		send_item(bfgql_pkg::OP_END, 8'($urandom), 8'($urandom), 1'($urandom),
			24'($urandom), 24'($urandom));
	endtask

	task automatic random_regs(input bit extreme);
		logic [15:0] val;
		for (int r = 0; r < 8; r++) begin
			if (extreme)
				val = ($urandom_range(0, 1) != 0) ? 16'hffff : 16'h0000;
			else if (r[2:0] == bfgql_pkg::REG_CELL_W || r[2:0] == bfgql_pkg::REG_CELL_H)
				val = 16'($urandom_range(0, 4096));
			else if ($urandom_range(0, 1) != 0)
				val = 16'($urandom_range(0, 600));
			else
				val = 16'($urandom);
			write_reg(r[2:0], val);
		end
	endtask

	initial begin
		in_valid = 0; cfg_we = 0; cfg_index = '0; cfg_data = '0;
		opcode = '0; char_code = '0; glyph_index = '0; entry_valid = 0;
		origin_x = '0; origin_y = '0; arst_n = 0; quiet_tail = 0; long_hold = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty strings, unmapped glyphs, map extremes
		send_item(bfgql_pkg::OP_END, 8'h00, 8'h00, 1'b0, 24'sd0, 24'sd0);
		send_item(bfgql_pkg::OP_START, 8'h00, 8'h00, 1'b0, 24'sh7fffff, 24'sh800000);
		send_char(8'h41);
		send_item(bfgql_pkg::OP_END, 8'hff, 8'hff, 1'b1, 24'sd0, 24'sd0);
		send_item(bfgql_pkg::OP_MAP_LOAD, 8'h00, 8'hff, 1'b1, 24'sd0, 24'sd0);
		send_item(bfgql_pkg::OP_MAP_LOAD, 8'hff, 8'h00, 1'b1, 24'sd0, 24'sd0);
		send_item(bfgql_pkg::OP_MAP_LOAD, 8'h41, 8'h11, 1'b1, 24'sd0, 24'sd0);
		send_item(bfgql_pkg::OP_START, 8'h00, 8'h00, 1'b0, 24'sd100, 24'sd200);
		send_char(8'h00); send_char(8'hff); send_char(bfgql_pkg::CHAR_CR);
		send_char(bfgql_pkg::CHAR_TAB);
		send_char(8'h41); send_char(bfgql_pkg::CHAR_LF); send_char(8'h41);
		send_item(bfgql_pkg::OP_END, 8'h00, 8'h00, 1'b0, 24'sd0, 24'sd0);
		send_item(bfgql_pkg::OP_END, 8'h00, 8'h00, 1'b0, 24'sd0, 24'sd0);
		send_char(8'h41);
		send_item(bfgql_pkg::OP_START, 8'h00, 8'h00, 1'b0, 24'sh7fff00, 24'sh800100);
		send_char(8'h00); send_char(bfgql_pkg::CHAR_TAB); send_char(8'hff);
		send_item(bfgql_pkg::OP_END, 8'h00, 8'h00, 1'b0, 24'sd0, 24'sd0);
		drain();

		// extremes: full registers, then each register full or zero at random, with wrap
		write_reg(bfgql_pkg::REG_CELL_W, 16'hffff);
		write_reg(bfgql_pkg::REG_CELL_H, 16'hffff);
		write_reg(bfgql_pkg::REG_SPACING_X, 16'hffff);
		write_reg(bfgql_pkg::REG_SPACING_Y, 16'hffff);
		write_reg(bfgql_pkg::REG_TAB_CELLS, 16'h000f);
		write_reg(bfgql_pkg::REG_LINE_LIM, 16'h00ff);
		write_reg(bfgql_pkg::REG_CROP_U, 16'hffff);
		write_reg(bfgql_pkg::REG_CROP_V, 16'hffff);
		load_map(1, 256);
		random_string(15);
		drain();
		random_regs(1);
		random_string(15);
		drain();

		// long receiver hold while the sender keeps offering
		write_reg(bfgql_pkg::REG_LINE_LIM, 16'd3);
		write_reg(bfgql_pkg::REG_TAB_CELLS, 16'd5);
		write_reg(bfgql_pkg::REG_CELL_W, 16'd256);
		write_reg(bfgql_pkg::REG_CELL_H, 16'd512);
		write_reg(bfgql_pkg::REG_CROP_U, 16'd100);
		write_reg(bfgql_pkg::REG_CROP_V, 16'd50);
		long_hold = 1;
		random_string(30);
		drain();

		// random phases with fresh settings and maps
		for (int ph = 0; ph < 3; ph++) begin
			random_regs(0);
			if (ph[0]) write_reg(bfgql_pkg::REG_LINE_LIM, 16'd0);
			if (ph == 2) load_map(0, 32);
			for (int s = 0; s < 3; s++) random_string($urandom_range(4, 12));
			drain();
		end

		// closing part with no idling
		quiet_tail = 1;
		random_string(15);
		drain();

		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#20ms;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== bitmap_font_glyph_quad_layout.f =====
hw/rtl/bfgql_pkg.sv
hw/rtl/bitmap_font_glyph_quad_layout.sv
sim/glyph_layout_checker.sv
sim/bitmap_font_glyph_quad_layout_tb.sv
